FILE: src/ptom_pkg.sv
// Package for the price-time order matcher: result kind codes and defaults.
// Used by every module of the block; depends on nothing.
`default_nettype none
package ptom_pkg;
  localparam int MaxOrdersDefault = 64;

  typedef enum logic [2:0] {
    KIND_TRADE     = 3'd0,
    KIND_RESTED    = 3'd1,
    KIND_DUPLICATE = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_UNKNOWN   = 3'd4,
    KIND_FULL      = 3'd5
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic scan_start; // clear scan accumulators
    logic scan_step;  // examine slot at scan index
    logic do_cancel;  // invalidate the found slot
    logic do_trade;   // apply a trade against the best slot
    logic do_rest;    // place remainder in the free slot
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic id_found;
    logic best_found;
    logic free_found;
    logic qty_zero;
    logic is_cancel;
  } stat_t;
endpackage
`default_nettype wire

FILE: src/ptom_datapath.sv
// Datapath of the order matcher: the order table, a slot-serial scanner and the
// trade arithmetic. Depends on ptom_pkg for the command and status structs.
`default_nettype none
module ptom_datapath #(
  parameter int MaxOrders = ptom_pkg::MaxOrdersDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ptom_pkg::cmd_t  cmd,
  output ptom_pkg::stat_t      stat,
  input  wire logic            in_op,
  input  wire logic [31:0]     in_id,
  input  wire logic            in_side,
  input  wire logic [31:0]     in_qty,
  input  wire logic [31:0]     in_px,
  output logic [31:0]          t_price,
  output logic [31:0]          t_qty,
  output logic [31:0]          inc_id,
  output logic [31:0]          inc_left,
  output logic [31:0]          rest_id,
  output logic [31:0]          rest_left
);
  localparam int IdxW = (MaxOrders > 1) ? $clog2(MaxOrders) : 1;
  localparam int CntW = $clog2(MaxOrders + 1);

  logic [MaxOrders-1:0] valid;
  logic [31:0] mem_id    [MaxOrders];
  logic        mem_side  [MaxOrders];
  logic [31:0] mem_price [MaxOrders];
  logic [31:0] mem_qty   [MaxOrders];
  logic [31:0] mem_arr   [MaxOrders];
  logic [31:0] arrival;

  logic        op, side;
  logic [31:0] px, qty;
  logic [CntW-1:0] idx;
  logic [IdxW-1:0] sidx;
  logic        rd_en, rd_valid, rd_side;
  logic [IdxW-1:0] rd_slot;
  logic [31:0] rd_id, rd_price, rd_qty, rd_arr;
  logic        id_found, best_found, free_found;
  logic [IdxW-1:0] id_slot, best_slot, free_slot;
  logic [31:0] id_qty, best_id, best_price, best_qty, best_age;
  logic [31:0] cur_age, fill;
  logic cur_ok, better;

  assign sidx = idx[IdxW-1:0];

  // The scan reads one slot a cycle; the slot is judged in the next cycle from
  // the registered read data.
  assign cur_age = arrival - rd_arr;
  always_comb begin
    cur_ok = rd_valid && (rd_side != side) &&
             (side ? (rd_price >= px) : (rd_price <= px));
    if (!best_found) better = 1'b1;
    else if (rd_price != best_price)
      better = side ? (rd_price > best_price) : (rd_price < best_price);
    else better = cur_age > best_age;
  end
  assign fill = (qty < best_qty) ? qty : best_qty;

  always_ff @(posedge clk) begin
    rd_valid <= valid[sidx];
    rd_slot  <= sidx;
    rd_id    <= mem_id[sidx];
    rd_side  <= mem_side[sidx];
    rd_price <= mem_price[sidx];
    rd_qty   <= mem_qty[sidx];
    rd_arr   <= mem_arr[sidx];
    if (!rst && cmd.do_trade) mem_qty[best_slot] <= best_qty - fill;
    if (!rst && cmd.do_rest) begin
      mem_id[free_slot]    <= inc_id;
      mem_side[free_slot]  <= side;
      mem_price[free_slot] <= px;
      mem_qty[free_slot]   <= qty;
      mem_arr[free_slot]   <= arrival;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      arrival <= '0;
      idx     <= '0;
      rd_en   <= 1'b0;
    end else begin
      if (cmd.load) begin
        op <= in_op; side <= in_side; px <= in_px; qty <= in_qty;
        inc_id <= in_id; inc_left <= in_qty;
      end
      if (cmd.scan_start) begin
        idx <= '0; rd_en <= 1'b0;
        id_found <= 1'b0; best_found <= 1'b0; free_found <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          if (idx != CntW'(MaxOrders)) begin
            idx <= idx + CntW'(1); rd_en <= 1'b1;
          end else rd_en <= 1'b0;
        end
        if (rd_en) begin
          if (rd_valid && rd_id == inc_id && !id_found) begin
            id_found <= 1'b1; id_slot <= rd_slot; id_qty <= rd_qty;
          end
          if (!rd_valid && !free_found) begin
            free_found <= 1'b1; free_slot <= rd_slot;
          end
          if (cur_ok && better) begin
            best_found <= 1'b1; best_slot <= rd_slot; best_id <= rd_id;
            best_price <= rd_price; best_qty <= rd_qty; best_age <= cur_age;
          end
        end
      end
      if (cmd.do_cancel) begin
        valid[id_slot] <= 1'b0;
        inc_left <= id_qty;
      end
      if (cmd.do_trade) begin
        qty <= qty - fill;
        if (best_qty == fill) valid[best_slot] <= 1'b0;
        t_price   <= best_price;
        t_qty     <= fill;
        inc_left  <= qty - fill;
        rest_id   <= best_id;
        rest_left <= best_qty - fill;
      end
      if (cmd.do_rest) begin
        valid[free_slot] <= 1'b1;
        arrival <= arrival + 32'd1;
      end
    end
  end

  always_comb begin
    stat.scan_done  = (idx == CntW'(MaxOrders)) && !rd_en;
    stat.id_found   = id_found;
    stat.best_found = best_found;
    stat.free_found = free_found;
    stat.qty_zero   = (qty == 32'd0);
    stat.is_cancel  = op;
  end
endmodule
`default_nettype wire

FILE: src/ptom_ctrl.sv
// Controller of the order matcher: sequences scans, trades and results.
// Depends on ptom_pkg for command, status and kind codes.
`default_nettype none
module ptom_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ptom_pkg::cmd_t      cmd,
  input  wire ptom_pkg::stat_t stat,
  output ptom_pkg::kind_t     kind,
  output logic                rested_flag,
  output logic                last
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN_ID, S_DECIDE, S_SCAN_BEST, S_MATCH,
                            S_OUT} state_t;
  state_t state;
  logic traded, pend_trade, back_to_match, more;

  assign in_stall = (state != S_IDLE);
  assign more = !stat.qty_zero && stat.best_found;

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid; cmd.scan_start = in_valid;
      end
      S_SCAN_ID:   cmd.scan_step = !stat.scan_done;
      S_DECIDE: begin
        cmd.do_cancel  = stat.is_cancel && stat.id_found;
        cmd.scan_start = !stat.is_cancel && !stat.id_found;
      end
      S_SCAN_BEST: cmd.scan_step = !stat.scan_done;
      S_MATCH: begin
        if (more) begin
          cmd.do_trade = !pend_trade; cmd.scan_start = !pend_trade;
        end else cmd.do_rest = !stat.qty_zero && stat.free_found;
      end
      default:     ;
    endcase
  end

  // A trade result is held back until the next scan shows whether it is final;
  // it leaves before the next trade overwrites the datapath's result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; traded <= 1'b0; pend_trade <= 1'b0;
      back_to_match <= 1'b0;
      kind <= ptom_pkg::KIND_RESTED; rested_flag <= 1'b0; last <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_SCAN_ID; traded <= 1'b0; pend_trade <= 1'b0;
        end
        S_SCAN_ID: if (stat.scan_done) state <= S_DECIDE;
        S_DECIDE: begin
          back_to_match <= 1'b0;
          if (stat.is_cancel || stat.id_found) begin
            kind <= stat.is_cancel ? (stat.id_found ? ptom_pkg::KIND_CANCELLED
                                                    : ptom_pkg::KIND_UNKNOWN)
                                   : ptom_pkg::KIND_DUPLICATE;
            rested_flag <= 1'b0; last <= 1'b1; state <= S_OUT;
          end else state <= S_SCAN_BEST;
        end
        S_SCAN_BEST: if (stat.scan_done) state <= S_MATCH;
        S_MATCH: begin
          if (more && pend_trade) begin
            kind <= ptom_pkg::KIND_TRADE; rested_flag <= 1'b0; last <= 1'b0;
            pend_trade <= 1'b0; back_to_match <= 1'b1; state <= S_OUT;
          end else if (more) begin
            pend_trade <= 1'b1; traded <= 1'b1; state <= S_SCAN_BEST;
          end else begin
            last <= 1'b1; rested_flag <= cmd.do_rest; back_to_match <= 1'b0;
            if (traded) kind <= ptom_pkg::KIND_TRADE;
            else if (stat.qty_zero || cmd.do_rest) kind <= ptom_pkg::KIND_RESTED;
            else kind <= ptom_pkg::KIND_FULL;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= back_to_match ? S_MATCH : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/price_time_order_matcher_core.sv
// Top level of the price-time order matcher: controller and datapath.
// Depends on ptom_pkg, ptom_ctrl and ptom_datapath.
//
// One item at a time. Every item first takes a scan of the order table for the id,
// slot by slot with the registered table read. A cancel or a duplicate then gives
// its single result. An add then scans the table for the best opposite order, once
// for each trade and once more to find that no trade is left; each trade result but
// the last is handed out before the next trade is applied, and any remainder is
// placed in a free slot if one is found. Results are shown on registered outputs
// and held by stall.
`default_nettype none
module price_time_order_matcher_core #(
  parameter int MaxOrders = ptom_pkg::MaxOrdersDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [31:0] ord_id,
  input  wire logic        side,
  input  wire logic [31:0] quantity,
  input  wire logic [31:0] limit_price,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [31:0]      trade_price,
  output logic [31:0]      trade_quantity,
  output logic [31:0]      incoming_id,
  output logic [31:0]      incoming_left,
  output logic [31:0]      resting_id,
  output logic [31:0]      resting_left,
  output logic             rested_flag,
  output logic             last
);
  ptom_pkg::cmd_t  cmd;
  ptom_pkg::stat_t stat;
  ptom_pkg::kind_t k;
  logic [31:0] tp, tq, il, ri, rl;

  ptom_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd, .stat, .kind(k), .rested_flag, .last
  );

  ptom_datapath #(.MaxOrders(MaxOrders)) u_dp (
    .clk, .rst, .cmd, .stat,
    .in_op(op), .in_id(ord_id), .in_side(side), .in_qty(quantity),
    .in_px(limit_price),
    .t_price(tp), .t_qty(tq), .inc_id(incoming_id), .inc_left(il),
    .rest_id(ri), .rest_left(rl)
  );

  logic is_trade, zero_left;
  assign kind      = k;
  assign is_trade  = (k == ptom_pkg::KIND_TRADE);
  assign zero_left = (k == ptom_pkg::KIND_DUPLICATE) || (k == ptom_pkg::KIND_UNKNOWN);
  assign trade_price    = is_trade ? tp : 32'd0;
  assign trade_quantity = is_trade ? tq : 32'd0;
  assign resting_id     = is_trade ? ri : 32'd0;
  assign resting_left   = is_trade ? rl : 32'd0;
  assign incoming_left  = zero_left ? 32'd0 : il;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall || last) else $error("input taken during results");
  a_trade_commands: assert property (@(posedge clk) disable iff (rst)
    !(cmd.do_trade && cmd.do_rest)) else $error("trade and rest together");
  a_cancel_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_trade) |-> last) else $error("non-trade result not final");
endmodule
`default_nettype wire

FILE: sim/price_time_order_matcher_core_tb.sv
// Testbench for price_time_order_matcher_core: drives adds and cancels, predicts
// the trades and the resting book in price-time priority, checks every result item.
// Depends on ptom_pkg and the core RTL.
`default_nettype none
module price_time_order_matcher_core_tb;
  localparam int NumSlots = ptom_pkg::MaxOrdersDefault;
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_CANCEL = 1'b1;
  localparam logic SIDE_BUY = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] ord_id;
    logic        side;
    logic [31:0] quantity;
    logic [31:0] limit_price;
  } order_t;

  typedef struct packed {
    ptom_pkg::kind_t kind;
    logic [31:0] trade_price;
    logic [31:0] trade_quantity;
    logic [31:0] incoming_id;
    logic [31:0] incoming_left;
    logic [31:0] resting_id;
    logic [31:0] resting_left;
    logic        rested_flag;
    logic        last;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = 1'b0;
  logic [31:0] ord_id = '0;
  logic side = 1'b0;
  logic [31:0] quantity = '0;
  logic [31:0] limit_price = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] kind;
  logic [31:0] trade_price, trade_quantity, incoming_id, incoming_left;
  logic [31:0] resting_id, resting_left;
  logic rested_flag, last;

  price_time_order_matcher_core i_dut (.*);

  always #1 clk = ~clk;

  // Predicted book.
  logic        book_valid[NumSlots];
  logic [31:0] book_id[NumSlots];
  logic        book_side[NumSlots];
  logic [31:0] book_price[NumSlots];
  logic [31:0] book_qty[NumSlots];
  logic [31:0] book_stamp[NumSlots];
  logic [31:0] stamp_count;

  order_t  pending_orders[$];
  report_t expected_reports[$];
  int mismatches = 0;
  int reports_seen = 0;
  int trades_seen = 0;

  function automatic report_t make_report(ptom_pkg::kind_t k, logic [31:0] id,
                                          logic [31:0] left, logic rested);
    report_t r;
    r = '0;
    r.kind = k;
    r.incoming_id = id;
    r.incoming_left = left;
    r.rested_flag = rested;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < NumSlots; i++)
      if (book_valid[i] && book_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int best_opposite(logic s, logic [31:0] px);
    int best;
    logic better;
    best = -1;
    for (int i = 0; i < NumSlots; i++) begin
      if (!book_valid[i] || book_side[i] == s) continue;
      if (s == SIDE_BUY ? (book_price[i] > px) : (book_price[i] < px)) continue;
      if (best < 0) begin
        best = i;
      end else begin
        if (book_price[i] != book_price[best])
          better = (s == SIDE_BUY) ? (book_price[i] < book_price[best])
                                   : (book_price[i] > book_price[best]);
        else
          better = (stamp_count - book_stamp[i]) > (stamp_count - book_stamp[best]);
        if (better) best = i;
      end
    end
    return best;
  endfunction

  task automatic predict_order(order_t o);
    int s, n;
    logic [31:0] qty, t;
    logic rested;
    report_t r, trades[$];
    if (o.op == OP_CANCEL) begin
      s = find_order(o.ord_id);
      if (s < 0) begin
        expected_reports.push_back(make_report(ptom_pkg::KIND_UNKNOWN, o.ord_id, '0,
                                               1'b0));
      end else begin
        book_valid[s] = 1'b0;
        expected_reports.push_back(make_report(ptom_pkg::KIND_CANCELLED, o.ord_id,
                                               book_qty[s], 1'b0));
      end
      return;
    end
    if (find_order(o.ord_id) >= 0) begin
      expected_reports.push_back(make_report(ptom_pkg::KIND_DUPLICATE, o.ord_id, '0,
                                             1'b0));
      return;
    end
    qty = o.quantity;
    n = 0;
    rested = 1'b0;
    while (qty != 0 && n < NumSlots) begin
      s = best_opposite(o.side, o.limit_price);
      if (s < 0) break;
      t = (qty < book_qty[s]) ? qty : book_qty[s];
      qty -= t;
      book_qty[s] -= t;
      if (book_qty[s] == 0) book_valid[s] = 1'b0;
      r = '0;
      r.kind = ptom_pkg::KIND_TRADE;
      r.trade_price = book_price[s];
      r.trade_quantity = t;
      r.incoming_id = o.ord_id;
      r.incoming_left = qty;
      r.resting_id = book_id[s];
      r.resting_left = book_qty[s];
      trades.push_back(r);
      n++;
    end
    if (qty != 0) begin
      for (int i = 0; i < NumSlots; i++) begin
        if (!book_valid[i]) begin
          book_valid[i] = 1'b1;
          book_id[i] = o.ord_id;
          book_side[i] = o.side;
          book_price[i] = o.limit_price;
          book_qty[i] = qty;
          book_stamp[i] = stamp_count;
          stamp_count++;
          rested = 1'b1;
          break;
        end
      end
    end
    if (n > 0) begin
      trades[n-1].rested_flag = rested;
      trades[n-1].last = 1'b1;
      foreach (trades[i]) expected_reports.push_back(trades[i]);
    end else if (qty == 0) begin
      expected_reports.push_back(make_report(ptom_pkg::KIND_RESTED, o.ord_id, '0, 1'b0));
    end else if (rested) begin
      expected_reports.push_back(make_report(ptom_pkg::KIND_RESTED, o.ord_id, qty, 1'b1));
    end else begin
      expected_reports.push_back(make_report(ptom_pkg::KIND_FULL, o.ord_id, qty, 1'b0));
    end
  endtask

  function automatic order_t new_add(logic [31:0] id, logic s, logic [31:0] q,
                                     logic [31:0] px);
    order_t o;
    o.op = OP_ADD;
    o.ord_id = id;
    o.side = s;
    o.quantity = q;
    o.limit_price = px;
    return o;
  endfunction

  function automatic order_t new_cancel(logic [31:0] id);
    order_t o;
    o = '0;
    o.op = OP_CANCEL;
    o.ord_id = id;
    o.side = 1'($urandom_range(1));
    o.quantity = $urandom;
    o.limit_price = $urandom;
    return o;
  endfunction

  // Driver: bursts of items with random gaps, payload held while stalled.
  int burst_left = 0;
  int gap_left = 0;
  int items_sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_order({op, ord_id, side, quantity, limit_price});
        items_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_orders.size() > 0) begin
        {op, ord_id, side, quantity, limit_price} <= pending_orders[0];
        pending_orders.delete(0);
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(8);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(200);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    report_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {ptom_pkg::kind_t'(kind), trade_price, trade_quantity, incoming_id,
             incoming_left, resting_id, resting_left, rested_flag, last};
      reports_seen++;
      if (kind == ptom_pkg::KIND_TRADE) trades_seen++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
      end else begin
        want = expected_reports[0];
        expected_reports.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("result item differs: expected %p, got %p", want, got);
        end
      end
    end
    stall_phase = (stall_phase + 1) % 300;
    out_stall <= (stall_phase < 100) ? 1'b0 : ($urandom_range(3) == 0);
  end

  logic [31:0] used_ids[$];

  function automatic logic [31:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(9) < 8)
      return used_ids[$urandom_range(used_ids.size() - 1)];
    return $urandom;
  endfunction

  initial begin
    logic [31:0] id, base;
    order_t o;
    for (int i = 0; i < NumSlots; i++) book_valid[i] = 1'b0;
    stamp_count = '0;
    // Directed part: extremes, crossing on both sides, equal price ordering,
    // unknown cancel and zero quantity.
    pending_orders.push_back(new_add(32'h0, SIDE_SELL, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_orders.push_back(new_add(32'hFFFF_FFFF, SIDE_BUY, 32'd5, 32'h0));
    pending_orders.push_back(new_add(32'd10, SIDE_SELL, 32'd3, 32'd100));
    pending_orders.push_back(new_add(32'd11, SIDE_SELL, 32'd4, 32'd100));
    pending_orders.push_back(new_add(32'd12, SIDE_SELL, 32'd2, 32'd99));
    pending_orders.push_back(new_add(32'd13, SIDE_BUY, 32'd8, 32'd100));
    pending_orders.push_back(new_add(32'd12, SIDE_BUY, 32'd1, 32'd1));
    pending_orders.push_back(new_add(32'd14, SIDE_BUY, 32'd0, 32'd7));
    pending_orders.push_back(new_cancel(32'd9999));
    pending_orders.push_back(new_cancel(32'd11));
    pending_orders.push_back(new_add(32'd15, SIDE_SELL, 32'd20, 32'd0));
    pending_orders.push_back(new_add(32'd16, SIDE_BUY, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_orders.push_back(new_cancel(32'hFFFF_FFFF));
    pending_orders.push_back(new_cancel(32'h0));
    pending_orders.push_back(new_cancel(32'd16));
    // Fill the book to the brim with non-crossing buys, then overflow it.
    for (int i = 0; i < NumSlots + 2; i++)
      pending_orders.push_back(new_add(32'd1000 + i, SIDE_BUY, 32'd1 + i, 32'd10));
    pending_orders.push_back(new_add(32'd2000, SIDE_SELL, 32'd300, 32'd10));
    // Random part: prices in a narrow band so crossing is frequent, ids reused.
    base = 32'd500;
    for (int n = 0; n < 148; n++) begin
      if ($urandom_range(9) < 3) begin
        o = new_cancel(pick_id());
      end else begin
        id = ($urandom_range(19) == 0) ? pick_id() : $urandom;
        o = new_add(id, 1'($urandom_range(1)),
                    ($urandom_range(15) == 0) ? $urandom : $urandom_range(1, 20),
                    ($urandom_range(15) == 0) ? $urandom : base + $urandom_range(8));
        used_ids.push_back(id);
      end
      pending_orders.push_back(o);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    wait (pending_orders.size() == 0 && !in_valid);
    wait (expected_reports.size() == 0);
    repeat (200) @(posedge clk);
    $display("Ran %0d items through the book; %0d result items, %0d of them trades.",
             items_sent, reports_seen, trades_seen);
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("price_time_order_matcher_core: match");
    else
      $display("price_time_order_matcher_core: mismatch");
    $finish;
  end

  // An item can need a scan for its id and up to 65 scans for the best order, behind stalls and gaps.
  initial begin
    #40000000;
    $display("price_time_order_matcher_core: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
